// ===== rtl/nls_pkg.sv =====
// Shared types and constants for the numeric literal scanner.
// Holds the character class record passed from the front end to the scan engine.
// No dependencies.
package nls_pkg;

  localparam int CharW      = 21;
  localparam int LenMax     = 1023;
  localparam int LenW       = $clog2(LenMax + 1);
  localparam int TokLenW    = 10;
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int PaddrW     = 3;
  localparam int RegIdxW    = PaddrW - 2;

  localparam logic [RegIdxW-1:0] RegStrictFraction = RegIdxW'(0);

  typedef struct packed {
    logic eol;
    logic zero;
    logic digit;
    logic nonoct;
    logic bin;
    logic xdigit;
    logic word;
    logic dot;
    logic under;
    logic exp_e;
    logic exp_p;
    logic radix_b;
    logic radix_x;
    logic sign;
    logic int_suf;
    logic flt_suf;
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic        start;
  } scan_item_t;

endpackage

// ===== rtl/nls_front.sv =====
// Front end of the numeric literal scanner: input handshake and character classing.
// Depends on nls_pkg; feeds nls_queue.
module nls_front import nls_pkg::*; (
  input  logic [CharW-1:0] char_code_i,
  input  logic             begin_req_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             q_full_i,
  output logic             push_o,
  output scan_item_t       item_o
);

  logic       ascii;
  logic [6:0] lo;
  logic       lower;
  logic       upper;

  assign ascii = (char_code_i[CharW-1:7] == '0);
  assign lo    = char_code_i[6:0];
  assign lower = ascii && (lo >= 7'h61) && (lo <= 7'h7a);
  assign upper = ascii && (lo >= 7'h41) && (lo <= 7'h5a);

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    item_o.start       = begin_req_i;
    item_o.cls.eol     = (char_code_i == '0);
    item_o.cls.zero    = ascii && (lo == 7'h30);
    item_o.cls.digit   = ascii && (lo >= 7'h30) && (lo <= 7'h39);
    item_o.cls.nonoct  = ascii && ((lo == 7'h38) || (lo == 7'h39));
    item_o.cls.bin     = ascii && ((lo == 7'h30) || (lo == 7'h31));
    item_o.cls.xdigit  = item_o.cls.digit ||
                         (ascii && (lo >= 7'h61) && (lo <= 7'h66)) ||
                         (ascii && (lo >= 7'h41) && (lo <= 7'h46));
    item_o.cls.under   = ascii && (lo == 7'h5f);
    item_o.cls.word    = item_o.cls.digit || lower || upper || item_o.cls.under;
    item_o.cls.dot     = ascii && (lo == 7'h2e);
    item_o.cls.exp_e   = ascii && ((lo == 7'h65) || (lo == 7'h45));
    item_o.cls.exp_p   = ascii && ((lo == 7'h70) || (lo == 7'h50));
    item_o.cls.radix_b = ascii && ((lo == 7'h62) || (lo == 7'h42));
    item_o.cls.radix_x = ascii && ((lo == 7'h78) || (lo == 7'h58));
    item_o.cls.sign    = ascii && ((lo == 7'h2b) || (lo == 7'h2d));
    item_o.cls.int_suf = ascii && ((lo == 7'h67) || (lo == 7'h6c) || (lo == 7'h69) ||
                                   (lo == 7'h47) || (lo == 7'h4c) || (lo == 7'h49));
    item_o.cls.flt_suf = ascii && ((lo == 7'h64) || (lo == 7'h66) ||
                                   (lo == 7'h44) || (lo == 7'h46));
  end

endmodule

// ===== rtl/nls_queue.sv =====
// Short queue of classified characters between the front end and the scan engine.
// Depends on nls_pkg.
module nls_queue import nls_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  scan_item_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output scan_item_t pop_data_o,
  output logic       empty_o
);

  scan_item_t       mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]   count_q, count_d;

  assign full_o     = (count_q == (QPtrW+1)'(QueueDepth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (QPtrW+1)'(push_i) - (QPtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/nls_back.sv =====
// Scan engine of the numeric literal scanner: literal state machine and result register.
// Depends on nls_pkg; takes classified characters from nls_queue.
module nls_back import nls_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               strict_i,
  input  logic               q_empty_i,
  input  scan_item_t         q_item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [TokLenW-1:0] token_length_o,
  output logic               malformed_o
);

  typedef enum logic [4:0] {
    PhIdle         = 5'd0,
    PhZero         = 5'd1,
    PhDecInt       = 5'd2,
    PhDecDot       = 5'd3,
    PhFrac         = 5'd4,
    PhDecTail      = 5'd5,
    PhExpSign      = 5'd6,
    PhExpFirst     = 5'd7,
    PhExpDigits    = 5'd8,
    PhBinFirst     = 5'd9,
    PhBinDigits    = 5'd10,
    PhHexFirst     = 5'd11,
    PhHexDigits    = 5'd12,
    PhHexDotStart  = 5'd13,
    PhHexDot       = 5'd14,
    PhHexFrac      = 5'd15,
    PhHexpSign     = 5'd16,
    PhHexpFirst    = 5'd17,
    PhHexpDigits   = 5'd18,
    PhCheckEnd     = 5'd19,
    PhAbsorb       = 5'd20
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [LenW-1:0]    len_q, len_d;
  logic               octal_q, octal_d;
  logic               nonoct_q, nonoct_d;
  logic               float_q, float_d;
  logic               under_q, under_d;
  logic               out_valid_q, out_valid_d;
  logic [TokLenW-1:0] tok_q, tok_d;
  logic               bad_q, bad_d;

  char_class_t        c;
  logic               done;
  logic               res;
  logic               rbad;
  logic               tail;
  logic [LenW-1:0]    rlen;

  function automatic logic [LenW-1:0] sat_inc(input logic [LenW-1:0] v);
    return (v < LenW'(LenMax)) ? v + 1'b1 : v;
  endfunction

  assign pop_o          = !q_empty_i && (!out_valid_q || out_ready_i);
  assign out_valid_o    = out_valid_q;
  assign token_length_o = tok_q;
  assign malformed_o    = bad_q;
  assign c              = q_item_i.cls;

  always_comb begin
    phase_d  = phase_q;
    len_d    = len_q;
    octal_d  = octal_q;
    nonoct_d = nonoct_q;
    float_d  = float_q;
    under_d  = under_q;
    done     = 1'b0;
    res      = 1'b0;
    rbad     = 1'b0;
    tail     = 1'b0;
    rlen     = len_q;

    if (q_item_i.start) begin
      done     = 1'b1;
      phase_d  = PhIdle;
      len_d    = '0;
      octal_d  = 1'b0;
      nonoct_d = 1'b0;
      float_d  = 1'b0;
      under_d  = 1'b0;
      if (c.zero) begin
        len_d   = LenW'(1);
        phase_d = PhZero;
      end else if (c.digit) begin
        len_d   = LenW'(1);
        phase_d = PhDecInt;
      end else if (c.dot) begin
        phase_d = PhDecDot;
      end else begin
        res  = 1'b1;
        rlen = '0;
      end
    end else if (phase_q == PhIdle) begin
      done = 1'b1;
    end

    // Each block either finishes the step or moves on to a later block.
    if (!done && phase_d == PhZero) begin
      if (c.radix_b) begin
        len_d = sat_inc(len_d); under_d = 1'b0; phase_d = PhBinFirst; done = 1'b1;
      end else if (c.radix_x) begin
        len_d = sat_inc(len_d); under_d = 1'b0; phase_d = PhHexFirst; done = 1'b1;
      end else begin
        octal_d = 1'b1; phase_d = PhDecInt;
      end
    end

    if (!done && phase_d == PhDecInt) begin
      if (c.digit || c.under) begin
        if (c.nonoct) nonoct_d = 1'b1;
        len_d = sat_inc(len_d); under_d = c.under; done = 1'b1;
      end else if (c.eol) begin
        res = 1'b1; done = 1'b1;
      end else if (under_d) begin
        rbad = 1'b1; res = !c.word; tail = 1'b1; done = 1'b1;
      end else if (c.dot) begin
        phase_d = PhDecDot; done = 1'b1;
      end else begin
        phase_d = PhDecTail;
      end
    end

    if (!done && phase_d == PhDecDot) begin
      if (((len_d == '0) || strict_i) && !c.digit) begin
        res = 1'b1; done = 1'b1;
      end else begin
        len_d = sat_inc(len_d); under_d = 1'b0; float_d = 1'b1;
        if (c.eol) begin
          res = 1'b1; done = 1'b1;
        end else if (c.digit) begin
          len_d = sat_inc(len_d); phase_d = PhFrac; done = 1'b1;
        end else begin
          phase_d = PhDecTail;
        end
      end
    end

    if (!done && phase_d == PhFrac) begin
      if (c.digit || c.under) begin
        len_d = sat_inc(len_d); under_d = c.under; done = 1'b1;
      end else if (c.eol) begin
        res = 1'b1; done = 1'b1;
      end else if (under_d) begin
        rbad = 1'b1; res = !c.word; tail = 1'b1; done = 1'b1;
      end else begin
        phase_d = PhDecTail;
      end
    end

    if (!done && phase_d == PhDecTail) begin
      done = 1'b1;
      if (c.exp_e) begin
        len_d = sat_inc(len_d); under_d = 1'b0; float_d = 1'b1; phase_d = PhExpSign;
      end else if (c.flt_suf) begin
        len_d = sat_inc(len_d); under_d = 1'b0; float_d = 1'b1; phase_d = PhCheckEnd;
      end else if (c.eol) begin
        res = 1'b1;
      end else if (!float_d && octal_d && nonoct_d) begin
        rbad = 1'b1; res = !c.word; tail = 1'b1;
      end else if (!float_d && c.int_suf) begin
        len_d = sat_inc(len_d); under_d = 1'b0; phase_d = PhCheckEnd;
      end else begin
        res = !c.word; tail = 1'b1;
      end
    end

    if (!done && phase_d == PhExpSign) begin
      phase_d = PhExpFirst;
      if (c.sign) begin
        len_d = sat_inc(len_d); under_d = 1'b0; done = 1'b1;
      end
    end

    if (!done && phase_d == PhExpFirst) begin
      done = 1'b1;
      if (c.eol) begin
        res = 1'b1;
      end else if (!c.digit) begin
        rbad = 1'b1; res = !c.word; tail = 1'b1;
      end else begin
        len_d = sat_inc(len_d); under_d = 1'b0; phase_d = PhExpDigits;
      end
    end

    if (!done && phase_d == PhExpDigits) begin
      done = 1'b1;
      if (c.digit || c.under) begin
        len_d = sat_inc(len_d); under_d = c.under;
      end else if (c.eol) begin
        res = 1'b1;
      end else if (under_d) begin
        rbad = 1'b1; res = !c.word; tail = 1'b1;
      end else if (c.flt_suf) begin
        len_d = sat_inc(len_d); under_d = 1'b0; phase_d = PhCheckEnd;
      end else begin
        res = !c.word; tail = 1'b1;
      end
    end

    if (!done && phase_d == PhHexpSign) begin
      phase_d = PhHexpFirst;
      if (c.sign) begin
        len_d = sat_inc(len_d); under_d = 1'b0; done = 1'b1;
      end
    end

    if (!done && phase_d == PhHexpFirst) begin
      done = 1'b1;
      if (c.eol) begin
        res = 1'b1;
      end else if (!c.digit) begin
        rbad = 1'b1; res = !c.word; tail = 1'b1;
      end else begin
        len_d = sat_inc(len_d); under_d = 1'b0; phase_d = PhHexpDigits;
      end
    end

    if (!done && phase_d == PhHexpDigits) begin
      done = 1'b1;
      if (c.digit || c.under) begin
        len_d = sat_inc(len_d); under_d = c.under;
      end else if (under_d) begin
        rbad = 1'b1; res = !c.word; tail = 1'b1;
      end else if (c.flt_suf) begin
        len_d = sat_inc(len_d); under_d = 1'b0; phase_d = PhCheckEnd;
      end else begin
        res = !c.word; tail = 1'b1;
      end
    end

    if (!done && phase_d == PhBinFirst) begin
      done = 1'b1;
      if (c.eol) begin
        res = 1'b1;
      end else if (!c.bin) begin
        rbad = 1'b1; res = !c.word; tail = 1'b1;
      end else begin
        len_d = sat_inc(len_d); under_d = 1'b0; phase_d = PhBinDigits;
      end
    end

    if (!done && phase_d == PhBinDigits) begin
      done = 1'b1;
      if (c.bin || c.under) begin
        len_d = sat_inc(len_d); under_d = c.under;
      end else if (c.eol) begin
        res = 1'b1;
      end else if (under_d) begin
        rbad = 1'b1; res = !c.word; tail = 1'b1;
      end else if (c.int_suf) begin
        len_d = sat_inc(len_d); under_d = 1'b0; phase_d = PhCheckEnd;
      end else begin
        res = !c.word; tail = 1'b1;
      end
    end

    if (!done && phase_d == PhHexFirst) begin
      done = 1'b1;
      if (c.eol) begin
        res = 1'b1;
      end else if (c.dot) begin
        phase_d = PhHexDotStart;
      end else if (!c.xdigit) begin
        rbad = 1'b1; res = !c.word; tail = 1'b1;
      end else begin
        len_d = sat_inc(len_d); under_d = 1'b0; phase_d = PhHexDigits;
      end
    end

    if (!done && phase_d == PhHexDigits) begin
      done = 1'b1;
      if (c.xdigit || c.under) begin
        len_d = sat_inc(len_d); under_d = c.under;
      end else if (c.eol) begin
        res = 1'b1;
      end else if (under_d) begin
        rbad = 1'b1; res = !c.word; tail = 1'b1;
      end else if (c.int_suf) begin
        len_d = sat_inc(len_d); under_d = 1'b0; phase_d = PhCheckEnd;
      end else if (c.dot) begin
        float_d = 1'b1; phase_d = PhHexDot;
      end else if (c.exp_p) begin
        len_d = sat_inc(len_d); under_d = 1'b0; float_d = 1'b1; phase_d = PhHexpSign;
      end else begin
        res = !c.word; tail = 1'b1;
      end
    end

    if (!done && phase_d == PhHexDotStart) begin
      if (!c.xdigit) begin
        rbad = 1'b1; res = 1'b1; done = 1'b1;
      end else begin
        phase_d = PhHexDot;
      end
    end

    if (!done && phase_d == PhHexDot) begin
      if (strict_i && !c.xdigit) begin
        res = 1'b1; done = 1'b1;
      end else begin
        len_d = sat_inc(len_d); under_d = 1'b0; float_d = 1'b1; phase_d = PhHexFrac;
      end
    end

    if (!done && phase_d == PhHexFrac) begin
      done = 1'b1;
      if (c.xdigit || c.under) begin
        len_d = sat_inc(len_d); under_d = c.under;
      end else if (c.eol) begin
        res = 1'b1;
      end else if (c.exp_p) begin
        len_d = sat_inc(len_d); under_d = 1'b0; phase_d = PhHexpSign;
      end else begin
        rbad = 1'b1; res = !c.word; tail = 1'b1;
      end
    end

    if (!done && phase_d == PhCheckEnd) begin
      done = 1'b1;
      res  = !c.word;
      tail = 1'b1;
    end

    if (!done && phase_d == PhAbsorb) begin
      done = 1'b1;
      if (c.word) begin
        len_d = sat_inc(len_d); under_d = 1'b0;
      end else begin
        rbad = 1'b1; res = 1'b1;
      end
    end

    // A word character after the end of a literal is taken into the malformed tail.
    if (tail && c.word) begin
      len_d   = sat_inc(len_d);
      under_d = 1'b0;
      phase_d = PhAbsorb;
    end

    if (!done) begin
      phase_d  = PhIdle;
      len_d    = '0;
      octal_d  = 1'b0;
      nonoct_d = 1'b0;
      float_d  = 1'b0;
      under_d  = 1'b0;
    end

    if (res) begin
      rlen     = len_d;
      phase_d  = PhIdle;
      len_d    = '0;
      octal_d  = 1'b0;
      nonoct_d = 1'b0;
      float_d  = 1'b0;
      under_d  = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    tok_d       = tok_q;
    bad_d       = bad_q;
    if (pop_o && res) begin
      out_valid_d = 1'b1;
      tok_d       = TokLenW'(rlen);
      bad_d       = rbad;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    bad_q <= bad_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      len_q       <= '0;
      octal_q     <= 1'b0;
      nonoct_q    <= 1'b0;
      float_q     <= 1'b0;
      under_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        phase_q  <= phase_d;
        len_q    <= len_d;
        octal_q  <= octal_d;
        nonoct_q <= nonoct_d;
        float_q  <= float_d;
        under_q  <= under_d;
      end
    end
  end

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhIdle) |-> (len_q == '0 && !octal_q && !nonoct_q && !float_q && !under_q))
    else $error("idle scan engine holds stale literal state");

  a_no_pop_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !pop_o)
    else $error("character taken while result register is blocked");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(LenMax))
    else $error("literal length above saturation limit");

endmodule

// ===== rtl/numeric_literal_scanner_unit.sv =====
// Numeric literal scanner: characters go in on one channel, one length and
// malformed flag per literal come out on the other. The input channel takes
// one code point and a begin flag per request; a request with the begin flag
// set starts a new literal and drops any scan in progress. A code of zero
// marks end of line. Each result request carries the literal length
// (saturating at 1023) and a malformed flag.
// The front end classifies each character and writes it to a four-entry
// queue in the cycle it is accepted; the scan engine takes one character per
// cycle from the queue while no held result is blocked, and registers any
// result. A result is registered once the character that ends the literal
// has passed through the queue; a dot is settled only by the character after
// it. Sustained throughput is one character per cycle while results are taken.
// When the receiver stalls, the result register holds, the engine stops, the
// queue fills and in_ready_o drops after at most four more characters.
// Reset empties the queue, returns the engine to idle and sets strict_fraction
// to 1. Register 0 (byte address 0) holds strict_fraction in bit 0; the user
// must write it only while the block is idle; the block does not enforce this.
// Depends on nls_pkg, nls_front, nls_queue and nls_back.
module numeric_literal_scanner_unit import nls_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CharW-1:0]   char_code_i,
  input  logic               begin_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [TokLenW-1:0] token_length_o,
  output logic               malformed_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PaddrW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic             strict_q, strict_d;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;
  scan_item_t       push_item;
  scan_item_t       pop_item;
  logic [RegIdxW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PaddrW-1:2];
  assign prdata  = (reg_idx == RegStrictFraction) ? {31'b0, strict_q} : 32'b0;

  always_comb begin
    strict_d = strict_q;
    if (psel && penable && pwrite && (reg_idx == RegStrictFraction)) begin
      strict_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_q <= 1'b1;
    end else begin
      strict_q <= strict_d;
    end
  end

  nls_front u_front (
    .char_code_i (char_code_i),
    .begin_req_i (begin_req_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .q_full_i    (q_full),
    .push_o      (push),
    .item_o      (push_item)
  );

  nls_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (pop_item),
    .empty_o     (q_empty)
  );

  nls_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .strict_i       (strict_q),
    .q_empty_i      (q_empty),
    .q_item_i       (pop_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_length_o (token_length_o),
    .malformed_o    (malformed_o)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for numeric_literal_scanner_unit, with a character-level predictor.
// A queue-fed driver and a clocked monitor run; an APB task changes strict_fraction once traffic drains.
// Depends on nls_pkg and the numeric_literal_scanner_unit RTL.
module tb_top;
  import nls_pkg::*;

  localparam int CycleLimit = 400000;

  typedef enum logic [4:0] {
    LX_IDLE, LX_ZERO, LX_DEC_INT, LX_DEC_DOT, LX_FRAC, LX_DEC_TAIL,
    LX_EXP_SIGN, LX_EXP_FIRST, LX_EXP_DIGITS, LX_BIN_FIRST, LX_BIN_DIGITS,
    LX_HEX_FIRST, LX_HEX_DIGITS, LX_HEX_DOT_START, LX_HEX_DOT, LX_HEX_FRAC,
    LX_HEXP_SIGN, LX_HEXP_FIRST, LX_HEXP_DIGITS, LX_CHECK_END, LX_ABSORB
  } lex_phase_e;

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             start;
  } lit_char_t;

  typedef struct packed {
    logic [TokLenW-1:0] len;
    logic               bad;
  } token_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [CharW-1:0]   char_code_i = '0;
  logic               begin_req_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [TokLenW-1:0] token_length_o;
  logic               malformed_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PaddrW-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  lit_char_t   lit_chars[$];
  token_t      expected_tokens[$];
  int          err_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          stall_left = 0;
  logic        stall_kick = 1'b0;
  int          n_pushed = 0;

  logic        lx_strict = 1'b1;
  lex_phase_e  lx_phase = LX_IDLE;
  logic [9:0]  lx_len = '0;
  logic        lx_oct = 1'b0;
  logic        lx_nonoct = 1'b0;
  logic        lx_flt = 1'b0;
  logic        lx_prev_us = 1'b0;

  numeric_literal_scanner_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_code_i    (char_code_i),
    .begin_req_i    (begin_req_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_length_o (token_length_o),
    .malformed_o    (malformed_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #10 clk_i = ~clk_i;

  function automatic bit is_dig(input int unsigned c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_hex(input int unsigned c);
    return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic bit is_word_ch(input int unsigned c);
    return is_dig(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_int_suf(input int unsigned c);
    return c == "g" || c == "l" || c == "i" || c == "G" || c == "L" || c == "I";
  endfunction

  function automatic bit is_flt_suf(input int unsigned c);
    return c == "d" || c == "f" || c == "D" || c == "F";
  endfunction

  function automatic void lex_clear();
    lx_phase = LX_IDLE;
    lx_len = '0;
    lx_oct = 1'b0;
    lx_nonoct = 1'b0;
    lx_flt = 1'b0;
    lx_prev_us = 1'b0;
  endfunction

  function automatic void bump(input bit us);
    if (lx_len < 10'(LenMax)) lx_len = lx_len + 10'd1;
    lx_prev_us = us;
  endfunction

  function automatic bit emit_tok(input bit b, output token_t t);
    t.len = lx_len;
    t.bad = b;
    lex_clear();
    return 1'b1;
  endfunction

  function automatic bit close_at(input int unsigned c, input bit b, output token_t t);
    t = '0;
    if (is_word_ch(c)) begin
      bump(1'b0);
      lx_phase = LX_ABSORB;
      return 1'b0;
    end
    return emit_tok(b, t);
  endfunction

  // Advances the literal recognizer by one accepted character; returns 1 when a token ends.
  function automatic bit lex_step(input logic [CharW-1:0] code, input logic start,
                                  output token_t t);
    int unsigned c;
    c = code;
    t = '0;
    if (start) begin
      lex_clear();
      if (c == "0") begin
        bump(1'b0);
        lx_phase = LX_ZERO;
        return 1'b0;
      end
      if (is_dig(c)) begin
        bump(1'b0);
        lx_phase = LX_DEC_INT;
        return 1'b0;
      end
      if (c == ".") begin
        lx_phase = LX_DEC_DOT;
        return 1'b0;
      end
      return emit_tok(1'b0, t);
    end
    if (lx_phase == LX_IDLE) return 1'b0;
    forever begin
      case (lx_phase)
        LX_ZERO: begin
          if (c == "b" || c == "B") begin
            bump(1'b0); lx_phase = LX_BIN_FIRST; return 1'b0;
          end
          if (c == "x" || c == "X") begin
            bump(1'b0); lx_phase = LX_HEX_FIRST; return 1'b0;
          end
          lx_oct = 1'b1;
          lx_phase = LX_DEC_INT;
        end
        LX_DEC_INT: begin
          if (is_dig(c) || c == "_") begin
            if (c == "8" || c == "9") lx_nonoct = 1'b1;
            bump(c == "_");
            return 1'b0;
          end
          if (c == 0) return emit_tok(1'b0, t);
          if (lx_prev_us) return close_at(c, 1'b1, t);
          if (c == ".") begin
            lx_phase = LX_DEC_DOT; return 1'b0;
          end
          lx_phase = LX_DEC_TAIL;
        end
        LX_DEC_DOT: begin
          if ((lx_len == 0 || lx_strict) && !is_dig(c)) return emit_tok(1'b0, t);
          bump(1'b0);
          lx_flt = 1'b1;
          if (c == 0) return emit_tok(1'b0, t);
          if (is_dig(c)) begin
            bump(1'b0); lx_phase = LX_FRAC; return 1'b0;
          end
          lx_phase = LX_DEC_TAIL;
        end
        LX_FRAC: begin
          if (is_dig(c) || c == "_") begin
            bump(c == "_"); return 1'b0;
          end
          if (c == 0) return emit_tok(1'b0, t);
          if (lx_prev_us) return close_at(c, 1'b1, t);
          lx_phase = LX_DEC_TAIL;
        end
        LX_DEC_TAIL: begin
          if (c == "e" || c == "E") begin
            bump(1'b0); lx_flt = 1'b1; lx_phase = LX_EXP_SIGN; return 1'b0;
          end
          if (is_flt_suf(c)) begin
            bump(1'b0); lx_flt = 1'b1; lx_phase = LX_CHECK_END; return 1'b0;
          end
          if (c == 0) return emit_tok(1'b0, t);
          if (!lx_flt) begin
            if (lx_oct && lx_nonoct) return close_at(c, 1'b1, t);
            if (is_int_suf(c)) begin
              bump(1'b0); lx_phase = LX_CHECK_END; return 1'b0;
            end
          end
          return close_at(c, 1'b0, t);
        end
        LX_EXP_SIGN, LX_HEXP_SIGN: begin
          lx_phase = (lx_phase == LX_EXP_SIGN) ? LX_EXP_FIRST : LX_HEXP_FIRST;
          if (c == "+" || c == "-") begin
            bump(1'b0); return 1'b0;
          end
        end
        LX_EXP_FIRST, LX_HEXP_FIRST: begin
          if (c == 0) return emit_tok(1'b0, t);
          if (!is_dig(c)) return close_at(c, 1'b1, t);
          bump(1'b0);
          lx_phase = (lx_phase == LX_EXP_FIRST) ? LX_EXP_DIGITS : LX_HEXP_DIGITS;
          return 1'b0;
        end
        LX_EXP_DIGITS: begin
          if (is_dig(c) || c == "_") begin
            bump(c == "_"); return 1'b0;
          end
          if (c == 0) return emit_tok(1'b0, t);
          if (lx_prev_us) return close_at(c, 1'b1, t);
          if (is_flt_suf(c)) begin
            bump(1'b0); lx_phase = LX_CHECK_END; return 1'b0;
          end
          return close_at(c, 1'b0, t);
        end
        LX_HEXP_DIGITS: begin
          if (is_dig(c) || c == "_") begin
            bump(c == "_"); return 1'b0;
          end
          if (lx_prev_us) return close_at(c, 1'b1, t);
          if (is_flt_suf(c)) begin
            bump(1'b0); lx_phase = LX_CHECK_END; return 1'b0;
          end
          return close_at(c, 1'b0, t);
        end
        LX_BIN_FIRST: begin
          if (c == 0) return emit_tok(1'b0, t);
          if (!(c == "0" || c == "1")) return close_at(c, 1'b1, t);
          bump(1'b0);
          lx_phase = LX_BIN_DIGITS;
          return 1'b0;
        end
        LX_BIN_DIGITS: begin
          if (c == "0" || c == "1" || c == "_") begin
            bump(c == "_"); return 1'b0;
          end
          if (c == 0) return emit_tok(1'b0, t);
          if (lx_prev_us) return close_at(c, 1'b1, t);
          if (is_int_suf(c)) begin
            bump(1'b0); lx_phase = LX_CHECK_END; return 1'b0;
          end
          return close_at(c, 1'b0, t);
        end
        LX_HEX_FIRST: begin
          if (c == 0) return emit_tok(1'b0, t);
          if (c == ".") begin
            lx_phase = LX_HEX_DOT_START; return 1'b0;
          end
          if (!is_hex(c)) return close_at(c, 1'b1, t);
          bump(1'b0);
          lx_phase = LX_HEX_DIGITS;
          return 1'b0;
        end
        LX_HEX_DIGITS: begin
          if (is_hex(c) || c == "_") begin
            bump(c == "_"); return 1'b0;
          end
          if (c == 0) return emit_tok(1'b0, t);
          if (lx_prev_us) return close_at(c, 1'b1, t);
          if (is_int_suf(c)) begin
            bump(1'b0); lx_phase = LX_CHECK_END; return 1'b0;
          end
          if (c == ".") begin
            lx_flt = 1'b1; lx_phase = LX_HEX_DOT; return 1'b0;
          end
          if (c == "p" || c == "P") begin
            bump(1'b0); lx_flt = 1'b1; lx_phase = LX_HEXP_SIGN; return 1'b0;
          end
          return close_at(c, 1'b0, t);
        end
        LX_HEX_DOT_START: begin
          if (!is_hex(c)) return emit_tok(1'b1, t);
          lx_phase = LX_HEX_DOT;
        end
        LX_HEX_DOT: begin
          if (lx_strict && !is_hex(c)) return emit_tok(1'b0, t);
          bump(1'b0);
          lx_flt = 1'b1;
          lx_phase = LX_HEX_FRAC;
        end
        LX_HEX_FRAC: begin
          if (is_hex(c) || c == "_") begin
            bump(c == "_"); return 1'b0;
          end
          if (c == 0) return emit_tok(1'b0, t);
          if (c == "p" || c == "P") begin
            bump(1'b0); lx_phase = LX_HEXP_SIGN; return 1'b0;
          end
          return close_at(c, 1'b1, t);
        end
        LX_CHECK_END: return close_at(c, 1'b0, t);
        LX_ABSORB: begin
          if (is_word_ch(c)) begin
            bump(1'b0); return 1'b0;
          end
          return emit_tok(1'b1, t);
        end
        default: begin
          lex_clear();
          return 1'b0;
        end
      endcase
    end
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Request driver: one character per accepted handshake, fed from lit_chars.
  always @(posedge clk_i) begin
    token_t    tok;
    lit_char_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        if (lex_step(char_code_i, begin_req_i, tok)) expected_tokens.push_back(tok);
      end
      if (!in_valid_i || in_ready_o) begin
        if (lit_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = lit_chars.pop_front();
          in_valid_i  <= 1'b1;
          char_code_i <= nxt.code;
          begin_req_i <= nxt.start;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_left > 0) stall_left <= stall_left - 1;
    else if (stall_kick) stall_left <= 400;
  end

  // Result monitor and receiver backpressure.
  always @(posedge clk_i) begin
    token_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_tokens.size() == 0) begin
          err_count <= err_count + 1;
          if (err_count < 10)
            $display("unexpected result: len=%0d malformed=%0b", token_length_o, malformed_o);
        end else begin
          want = expected_tokens.pop_front();
          if (token_length_o !== want.len || malformed_o !== want.bad) begin
            err_count <= err_count + 1;
            if (err_count < 10)
              $display("mismatch: expected len=%0d malformed=%0b, got len=%0d malformed=%0b",
                       want.len, want.bad, token_length_o, malformed_o);
          end
        end
      end
      out_ready_i <= (stall_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic add_char(input int unsigned c, input bit b);
    lit_chars.push_back('{code: CharW'(c), start: b});
    n_pushed++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i], i == 0);
  endtask

  function automatic int unsigned pick_from(input string s);
    return int'(s[$urandom_range(0, s.len() - 1)]);
  endfunction

  task automatic add_digits(input int n, input string set);
    for (int i = 0; i < n; i++) add_char(($urandom_range(0, 5) == 0) ? "_" : pick_from(set), 0);
  endtask

  task automatic add_exponent(input bit hexa);
    if (hexa) add_char(pick_from("pP"), 0);
    else add_char(pick_from("eE"), 0);
    if ($urandom_range(0, 1)) add_char(pick_from("+-"), 0);
    add_digits($urandom_range(0, 3), "0123456789");
  endtask

  task automatic add_term();
    case ($urandom_range(0, 9))
      0: add_char(" ", 0);
      1: add_char(";", 0);
      2: add_char(")", 0);
      3: add_char(0, 0);
      4: add_char(pick_from("gzqxLe_9aP"), 0);
      5: add_char(".", 0);
      6: add_char($urandom_range(0, 1114111), 0);
      7: add_char($urandom_range(128, 1114111), 0);
      8: add_char(pick_from("+-,"), 0);
      default: ;
    endcase
  endtask

  task automatic gen_literal();
    int n;
    case ($urandom_range(0, 11))
      0, 1: begin
        add_char(pick_from("123456789"), 1);
        add_digits($urandom_range(0, 5), "0123456789");
        if ($urandom_range(0, 2) == 0) begin
          add_char(".", 0);
          add_digits($urandom_range(0, 3), "0123456789");
        end
        if ($urandom_range(0, 3) == 0) add_exponent(1'b0);
        if ($urandom_range(0, 3) == 0) add_char(pick_from("gliGLIdfDF"), 0);
      end
      2: begin
        add_char("0", 1);
        add_digits($urandom_range(0, 5), ($urandom_range(0, 3) == 0) ? "0123456789" : "01234567");
        if ($urandom_range(0, 2) == 0) add_char(pick_from("gliGLIdfDF.eE"), 0);
      end
      3: begin
        add_char("0", 1);
        add_char(pick_from("bB"), 0);
        add_digits($urandom_range(0, 8), ($urandom_range(0, 4) == 0) ? "0123" : "01");
        if ($urandom_range(0, 2) == 0) add_char(pick_from("gliGLI"), 0);
      end
      4, 5: begin
        add_char("0", 1);
        add_char(pick_from("xX"), 0);
        add_digits($urandom_range(0, 6), "0123456789abcdefABCDEF");
        if ($urandom_range(0, 2) == 0) begin
          add_char(".", 0);
          add_digits($urandom_range(0, 3), "0123456789abcdefABCDEF");
        end
        if ($urandom_range(0, 1)) add_exponent(1'b1);
        if ($urandom_range(0, 2) == 0) add_char(pick_from("gliGLIdfDF"), 0);
      end
      6: begin
        push_text("0x.");
        add_digits($urandom_range(0, 3), "0123456789abcdefABCDEF");
        if ($urandom_range(0, 1)) add_exponent(1'b1);
      end
      7: begin
        add_char(".", 1);
        add_digits($urandom_range(0, 3), "0123456789");
        if ($urandom_range(0, 2) == 0) add_exponent(1'b0);
      end
      8, 9: begin
        add_char(pick_from("0123456789.0x"), 1);
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++)
          add_char(pick_from("0123456789_.eEpPxXbBabcdefABCDEFgliGLIdfDF+- "), 0);
      end
      10: add_char($urandom_range(0, 1114111), 1);
      default: begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) add_char($urandom_range(0, 1114111), 0);
      end
    endcase
    add_term();
  endtask

  task automatic fill_random(input int count);
    int stop_at;
    stop_at = n_pushed + count;
    while (n_pushed < stop_at) gen_literal();
  endtask

  task automatic wait_drained();
    while (lit_chars.size() != 0 || in_valid_i || expected_tokens.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input logic [31:0] val, output logic [31:0] rd);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PaddrW'({RegStrictFraction, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    if (wr) lx_strict = val[0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_strict(input bit v);
    logic [31:0] rd;
    add_char(0, 0);
    wait_drained();
    repeat (12) @(posedge clk_i);
    apb_access(1'b1, {31'b0, v}, rd);
    apb_access(1'b0, '0, rd);
    if (rd[0] !== v) begin
      err_count++;
      if (err_count <= 10) $display("strict_fraction readback: expected %0b, got %0b", v, rd[0]);
    end
  endtask

  initial begin
    int n;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_text("a");
    push_text(".;");
    push_text("0b2 ");
    push_text("09 ");
    push_text("1_");
    add_char(0, 0);
    push_text("0x. ");
    push_text("12");
    push_text("7");
    add_char(0, 0);
    add_char("z", 0);
    push_text("5");
    add_char(1114111, 0);
    push_text("0x1p1_");
    add_char(0, 0);

    set_strict(1'b0);
    send_idle_pct <= 23;
    recv_idle_pct <= 64;
    fill_random(110);

    set_strict(1'b1);
    send_idle_pct <= 64;
    recv_idle_pct <= 23;
    fill_random(55);
    add_char("1", 1);
    n = $urandom_range(1024, 1040);
    for (int i = 0; i < n; i++) add_char(pick_from("0123456789_"), 0);
    add_char(" ", 0);
    wait_drained();
    fill_random(55);

    set_strict(1'b0);
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    fill_random(110);
    while (lit_chars.size() > 60) @(posedge clk_i);
    stall_kick <= 1'b1;
    @(posedge clk_i);
    stall_kick <= 1'b0;
    add_char(0, 0);
    wait_drained();
    repeat (20) @(posedge clk_i);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
